### hw/rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// jst_pkg
// Types and constants shared by the JSON stream tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jst_pkg;

  // Input kind codes
  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Result event codes
  typedef enum logic [2:0] {
    EV_CHAR        = 3'd0,
    EV_NAME_END    = 3'd1,
    EV_OBJ_OPEN    = 3'd2,
    EV_ARR_OPEN    = 3'd3,
    EV_VALUE       = 3'd4,
    EV_VALUE_CLOSE = 3'd5,
    EV_EMPTY_CLOSE = 3'd6,
    EV_FAIL        = 3'd7
  } ev_t;

  // Document status
  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_DONE    = 2'd1,
    ST_FAILED  = 2'd2
  } status_t;

  // Characters of interest
  localparam logic [7:0] CH_SLASH         = 8'h2F;
  localparam logic [7:0] CH_STAR          = 8'h2A;
  localparam logic [7:0] CH_QUOTE         = 8'h22;
  localparam logic [7:0] CH_COLON         = 8'h3A;
  localparam logic [7:0] CH_COMMA         = 8'h2C;
  localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
  localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
  localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
  localparam logic [7:0] CH_SPACE         = 8'h20;
  localparam logic [7:0] CH_CR            = 8'h0D;
  localparam logic [7:0] CH_LF            = 8'h0A;

  typedef struct packed {
    logic       kind;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    ev_t        event_res;
    logic [7:0] char_out;
    logic [4:0] nest_level;
    logic       doc_done;
  } out_item_t;

  // Core step result: whether an item is produced, and its payload
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

endpackage

`default_nettype wire

### hw/rtl/jst_stream_if.sv
// ----------------------------------------------------------------------------
// jst_stream_if
// Valid/ready stream channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/jst_in_stage.sv
// ----------------------------------------------------------------------------
// jst_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire jst_pkg::in_item_t in_item,
  input  wire logic           advance,
  output logic                stage_valid,
  output jst_pkg::in_item_t   stage_item
);
  import jst_pkg::*;

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/jst_core.sv
// ----------------------------------------------------------------------------
// jst_core
// Tokenizer state and per-byte decode: comments, quoting, tokens, depth.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_core #(
  parameter int MAX_STRING = 256,
  parameter int MAX_DEPTH  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire jst_pkg::in_item_t item,
  output jst_pkg::step_res_t     res
);
  import jst_pkg::*;

  localparam int LEN_W   = $clog2(MAX_STRING);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(MAX_STRING - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  logic               in_quotes,        in_quotes_next;
  logic               reading_name,     reading_name_next;
  logic               in_line_comment,  in_line_comment_next;
  logic               in_block_comment, in_block_comment_next;
  logic               star_seen,        star_seen_next;
  logic               slash_seen,       slash_seen_next;
  logic [LEN_W-1:0]   string_length,    string_length_next;
  logic               empty_quoted_value, empty_quoted_value_next;
  logic [DEPTH_W-1:0] depth_count,      depth_count_next;
  status_t            run_status,       run_status_next;

  logic [7:0] c;
  logic       skip;
  logic       do_add;
  logic       do_open;
  logic       do_close;
  logic       close_has_value;
  logic       do_fail;
  ev_t        open_ev;

  assign c = item.text_byte;

  always_comb begin
    in_quotes_next          = in_quotes;
    reading_name_next       = reading_name;
    in_line_comment_next    = in_line_comment;
    in_block_comment_next   = in_block_comment;
    star_seen_next          = star_seen;
    slash_seen_next         = slash_seen;
    string_length_next      = string_length;
    empty_quoted_value_next = empty_quoted_value;
    depth_count_next        = depth_count;
    run_status_next         = run_status;
    skip            = 1'b0;
    do_add          = 1'b0;
    do_open         = 1'b0;
    do_close        = 1'b0;
    close_has_value = 1'b0;
    do_fail         = 1'b0;
    open_ev         = EV_OBJ_OPEN;
    res.emit            = 1'b0;
    res.item.event_res  = EV_CHAR;
    res.item.char_out   = 8'd0;
    res.item.nest_level = 5'(depth_count);
    res.item.doc_done   = 1'b0;

    if (item.kind == KIND_RESTART) begin
      in_quotes_next          = 1'b0;
      reading_name_next       = 1'b1;
      in_line_comment_next    = 1'b0;
      in_block_comment_next   = 1'b0;
      star_seen_next          = 1'b0;
      slash_seen_next         = 1'b0;
      string_length_next      = '0;
      empty_quoted_value_next = 1'b0;
      depth_count_next        = '0;
      run_status_next         = ST_RUNNING;
    end else if (run_status == ST_RUNNING) begin
      // Comment and whitespace filtering outside quotes
      if (!in_quotes) begin
        if (in_line_comment) begin
          if (c == CH_CR || c == CH_LF) begin
            in_line_comment_next = 1'b0;
          end
          skip = 1'b1;
        end else if (in_block_comment) begin
          if (star_seen && c == CH_SLASH) begin
            in_block_comment_next = 1'b0;
            star_seen_next        = 1'b0;
          end else begin
            star_seen_next = (c == CH_STAR);
          end
          skip = 1'b1;
        end else if (c == CH_SLASH) begin
          if (slash_seen) begin
            in_line_comment_next = 1'b1;
            slash_seen_next      = 1'b0;
          end else begin
            slash_seen_next = 1'b1;
          end
          skip = 1'b1;
        end else if (c == CH_STAR && slash_seen) begin
          in_block_comment_next = 1'b1;
          star_seen_next        = 1'b0;
          slash_seen_next       = 1'b0;
          skip = 1'b1;
        end else begin
          slash_seen_next = 1'b0;
          skip = (c <= CH_SPACE);
        end
      end

      if (!skip) begin
        if (c == CH_QUOTE) begin
          if (!reading_name && in_quotes && string_length == '0) begin
            empty_quoted_value_next = 1'b1;
          end
          in_quotes_next = !in_quotes;
        end else if (in_quotes) begin
          do_add = 1'b1;
        end else begin
          case (c)
            CH_COMMA: begin
              if (!(reading_name && string_length == '0)) begin
                string_length_next      = '0;
                empty_quoted_value_next = 1'b0;
                reading_name_next       = 1'b1;
                res.emit                = 1'b1;
                res.item.event_res      = EV_VALUE;
              end
            end
            CH_CLOSE_BRACE, CH_CLOSE_BRACKET: begin
              do_close        = 1'b1;
              close_has_value = (string_length != '0) ||
                                (!reading_name && empty_quoted_value);
            end
            CH_OPEN_BRACE: begin
              do_open = 1'b1;
              open_ev = EV_OBJ_OPEN;
            end
            CH_OPEN_BRACKET: begin
              do_open = 1'b1;
              open_ev = EV_ARR_OPEN;
            end
            CH_COLON: begin
              if (reading_name) begin
                string_length_next      = '0;
                empty_quoted_value_next = 1'b0;
                reading_name_next       = 1'b0;
                res.emit                = 1'b1;
                res.item.event_res      = EV_NAME_END;
              end else begin
                do_add = 1'b1;
              end
            end
            default: begin
              do_add = 1'b1;
            end
          endcase
        end
      end

      if (do_add) begin
        if (string_length >= LEN_LIMIT) begin
          do_fail = 1'b1;
        end else begin
          string_length_next = string_length + 1'b1;
          res.emit           = 1'b1;
          res.item.event_res = EV_CHAR;
          res.item.char_out  = c;
        end
      end

      if (do_open) begin
        if (depth_count >= DEPTH_MAX) begin
          do_fail = 1'b1;
        end else begin
          depth_count_next        = depth_count + 1'b1;
          string_length_next      = '0;
          empty_quoted_value_next = 1'b0;
          reading_name_next       = 1'b1;
          res.emit                = 1'b1;
          res.item.event_res      = open_ev;
          res.item.nest_level     = 5'(depth_count_next);
        end
      end

      if (do_close) begin
        if (depth_count == '0) begin
          do_fail = 1'b1;
        end else begin
          depth_count_next        = depth_count - 1'b1;
          string_length_next      = '0;
          empty_quoted_value_next = 1'b0;
          if (close_has_value) begin
            reading_name_next = 1'b1;
          end
          res.emit            = 1'b1;
          res.item.event_res  = close_has_value ? EV_VALUE_CLOSE : EV_EMPTY_CLOSE;
          res.item.nest_level = 5'(depth_count_next);
          if (depth_count_next == '0) begin
            res.item.doc_done = 1'b1;
            run_status_next   = ST_DONE;
          end
        end
      end

      // Fail reports the depth as it stood before this byte
      if (do_fail) begin
        run_status_next     = ST_FAILED;
        res.emit            = 1'b1;
        res.item.event_res  = EV_FAIL;
        res.item.char_out   = 8'd0;
        res.item.nest_level = 5'(depth_count);
        res.item.doc_done   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes          <= 1'b0;
      reading_name       <= 1'b1;
      in_line_comment    <= 1'b0;
      in_block_comment   <= 1'b0;
      star_seen          <= 1'b0;
      slash_seen         <= 1'b0;
      string_length      <= '0;
      empty_quoted_value <= 1'b0;
      depth_count        <= '0;
      run_status         <= ST_RUNNING;
    end else if (advance) begin
      in_quotes          <= in_quotes_next;
      reading_name       <= reading_name_next;
      in_line_comment    <= in_line_comment_next;
      in_block_comment   <= in_block_comment_next;
      star_seen          <= star_seen_next;
      slash_seen         <= slash_seen_next;
      string_length      <= string_length_next;
      empty_quoted_value <= empty_quoted_value_next;
      depth_count        <= depth_count_next;
      run_status         <= run_status_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/json_stream_tokenizer.sv
// An accepted byte is registered in the input stage; the core result item, if any,
// is registered in the output slot, and a byte with no result still steps the core.
// Throughput: one byte per cycle while the output is not stalled.
// Reset (rst, synchronous): clears both stage valids and all tokenizer state;
// a restart item clears the tokenizer state in-band and gives no result.
// ----------------------------------------------------------------------------
// json_stream_tokenizer
// Byte-serial JSON tokenizer with comment skipping, depth tracking and
// sticky failure.
// ----------------------------------------------------------------------------
`default_nettype none

module json_stream_tokenizer #(
  parameter int MAX_STRING = 256,
  parameter int MAX_DEPTH  = 16
) (
  input wire logic clk,
  input wire logic rst,
  jst_stream_if.sink   byte_in,
  jst_stream_if.source token_out
);
  import jst_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  step_res_t step;
  logic      out_valid;
  out_item_t out_item;

  // Move the staged item through the core when the result slot frees up
  assign advance = stage_valid && (!out_valid || token_out.ready);

  jst_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (byte_in.valid),
    .in_ready    (byte_in.ready),
    .in_item     (byte_in.payload),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  jst_core #(
    .MAX_STRING (MAX_STRING),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .res     (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step.emit;
    end else if (token_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      out_item <= step.item;
    end
  end

  assign token_out.valid   = out_valid;
  assign token_out.payload = out_item;

endmodule

`default_nettype wire
